@@ hw/rtl/sle_pkg.sv @@
// Shared types and codes for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

	// Request commands, as carried on the input tuser field.
	typedef enum logic [2:0] {
		CMD_GET       = 3'd0,
		CMD_FIND      = 3'd1,
		CMD_COUNT     = 3'd2,
		CMD_INSERT    = 3'd3,
		CMD_DEL_AT    = 3'd4,
		CMD_DEL_FIRST = 3'd5,
		CMD_DEL_ALL   = 3'd6,
		CMD_CLEAR     = 3'd7
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               command;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] result_value;
		logic [7:0]         found_position;
		logic [7:0]         match_count;
		logic [7:0]         list_size;
	} rsp_t;

endpackage

@@ hw/rtl/sequential_list_engine_unit.sv @@
// Top level of the sequential list engine: stream ports and result register.
`timescale 1ns / 1ps
// Get reads one entry, errors and clear answer without reading the store, find, count and
// the value deletes walk the whole list, and a delete or insert at position P walks the
// entries from P to the end; one store word is read per cycle.
// One request at a time; the next is taken once the walk of the current one ends and its
// result has moved to the output register.
// Reset clears the entry count and the handshake state; the entry store is not cleared
// and needs no clearing pass, since only entries below the count are ever read.
module sequential_list_engine_unit #(
	parameter int CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [7:0] position, [39:8] value
	input  logic [2:0]  s_tuser,  // [2:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [31:0] result_value, [39:32] found_position,
	                              // [47:40] match_count, [55:48] list_size
	output logic [1:0]  m_tuser   // [1:0] status
);

	import sle_pkg::*;

	req_t req;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_ready;
	logic seq_ready;
	rsp_t out_q;
	logic out_valid_q;

	// Unpack the incoming transfer into the request fields.
	assign req.command  = cmd_t'(s_tuser);
	assign req.position = s_tdata[7:0];
	assign req.value    = s_tdata[39:8];

	// The sequencer only looks at a request while it is idle, and takes it at once.
	assign s_tready = seq_ready;

	sle_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (seq_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// The output register frees the sequencer from the output side: a finished
	// result moves here as soon as the register is empty or being drained,
	// and the sequencer returns to idle to take the next request.
	assign rsp_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			out_q <= rsp;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_q.list_size, out_q.match_count, out_q.found_position,
		out_q.result_value};

endmodule

@@ hw/rtl/sle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/sle_seq.sv @@
// Sequencer, element compare unit and entry store of the list engine.
`timescale 1ns / 1ps

module sle_seq #(
	parameter int CAPACITY = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sle_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sle_pkg::rsp_t rsp
);

	import sle_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW >= 8) ? CW + 1 : 8;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_INS  = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] n_q;
	cmd_t          cmd_q;
	logic [AW-1:0] pm1_q;
	logic [31:0]   val_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] left_q;
	logic          dv_q;
	logic [AW-1:0] di_q;
	logic [CW-1:0] w_q;
	logic          hit_q;
	logic [CW-1:0] fpos_q;
	logic [CW-1:0] mcnt_q;
	logic [31:0]   rval_q;
	status_t       status_q;

	logic          rd_en;
	logic [31:0]   rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic          eq;
	logic          at_pos;
	logic          is_del;
	logic [LW-1:0] pos_x;
	logic [LW-1:0] n_x;
	logic          bad_rd;
	logic          bad_ins;

	sle_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rp_q),
		.rd_data (rd_data)
	);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign rd_en     = (state_q == S_SCAN) && (left_q != '0);

	assign pos_x   = LW'(req.position);
	assign n_x     = LW'(n_q);
	assign bad_rd  = (req.position == 8'd0) || (pos_x > n_x);
	assign bad_ins = (req.position == 8'd0) || (pos_x > n_x + LW'(1));

	assign is_del = (cmd_q == CMD_DEL_AT) || (cmd_q == CMD_DEL_FIRST) ||
		(cmd_q == CMD_DEL_ALL);

	// Shared compare unit: every returned word is tested against the request value.
	assign eq     = (rd_data == val_q);
	assign at_pos = (di_q == pm1_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(w_q);
		wr_data = rd_data;
		if ((state_q == S_SCAN) && dv_q) begin
			case (cmd_q)
				CMD_INSERT: begin
					wr_en   = 1'b1;
					wr_addr = di_q + AW'(1);
				end
				CMD_DEL_AT:    wr_en = !at_pos;
				CMD_DEL_FIRST: wr_en = !(eq && !hit_q);
				CMD_DEL_ALL:   wr_en = !eq;
				default:       wr_en = 1'b0;
			endcase
		end else if (state_q == S_INS) begin
			wr_en   = 1'b1;
			wr_addr = pm1_q;
			wr_data = val_q;
		end
	end

	assign rsp.status         = status_q;
	assign rsp.result_value   = rval_q;
	assign rsp.found_position = 8'(fpos_q);
	assign rsp.match_count    = 8'(mcnt_q);
	assign rsp.list_size      = 8'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			dv_q     <= 1'b0;
			left_q   <= '0;
			cmd_q    <= CMD_GET;
			pm1_q    <= '0;
			val_q    <= '0;
			rp_q     <= '0;
			di_q     <= '0;
			w_q      <= '0;
			hit_q    <= 1'b0;
			fpos_q   <= '0;
			mcnt_q   <= '0;
			rval_q   <= '0;
			status_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q    <= req.command;
						val_q    <= req.value;
						pm1_q    <= AW'(pos_x - LW'(1));
						status_q <= ST_OK;
						rval_q   <= '0;
						fpos_q   <= '0;
						mcnt_q   <= '0;
						hit_q    <= 1'b0;
						dv_q     <= 1'b0;
						rp_q     <= '0;
						w_q      <= '0;
						left_q   <= n_q;
						state_q  <= S_SCAN;
						case (req.command)
							CMD_GET: begin
								if (bad_rd) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end else begin
									rp_q   <= AW'(pos_x - LW'(1));
									left_q <= CW'(1);
								end
							end
							CMD_INSERT: begin
								if (bad_ins) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end else if (n_x == LW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_RESP;
								end else begin
									rp_q   <= AW'(n_q - CW'(1));
									left_q <= CW'(n_x - pos_x + LW'(1));
								end
							end
							CMD_DEL_AT: begin
								if (bad_rd) begin
									status_q <= ST_RANGE;
									state_q  <= S_RESP;
								end else begin
									rp_q   <= AW'(pos_x - LW'(1));
									w_q    <= CW'(pos_x - LW'(1));
									left_q <= CW'(n_x - pos_x + LW'(1));
								end
							end
							CMD_CLEAR: begin
								n_q     <= '0;
								state_q <= S_RESP;
							end
							default: begin
								// Find, count and the value deletes walk the whole list.
							end
						endcase
					end
				end
				S_SCAN: begin
					dv_q <= rd_en;
					di_q <= rp_q;
					if (rd_en) begin
						left_q <= left_q - CW'(1);
						if (cmd_q == CMD_INSERT) begin
							rp_q <= rp_q - AW'(1);
						end else begin
							rp_q <= rp_q + AW'(1);
						end
					end
					if (dv_q) begin
						if (is_del && wr_en) begin
							w_q <= w_q + CW'(1);
						end
						case (cmd_q)
							CMD_GET: rval_q <= rd_data;
							CMD_DEL_AT: begin
								if (at_pos) begin
									rval_q <= rd_data;
								end
							end
							CMD_FIND, CMD_DEL_FIRST: begin
								if (eq && !hit_q) begin
									hit_q  <= 1'b1;
									fpos_q <= CW'(di_q) + CW'(1);
									if (cmd_q == CMD_DEL_FIRST) begin
										mcnt_q <= CW'(1);
									end
								end
							end
							CMD_COUNT, CMD_DEL_ALL: begin
								if (eq) begin
									mcnt_q <= mcnt_q + CW'(1);
								end
							end
							default: begin
							end
						endcase
					end
					if (!rd_en && !dv_q) begin
						if (cmd_q == CMD_INSERT) begin
							state_q <= S_INS;
						end else begin
							if (is_del) begin
								n_q <= w_q;
							end
							state_q <= S_RESP;
						end
					end
				end
				S_INS: begin
					n_q     <= n_q + CW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
